// ===== rtl/core/adsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants for the ADSR envelope sampler.
// ----------------------------------------------------------------------------
package adsr_pkg;

	// Register map, word index into the APB space
	typedef enum logic [2:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_SUSTAIN = 3'd2,
		REG_RELEASE = 3'd3,
		REG_PEAK    = 3'd4
	} reg_idx_t;

	localparam logic [15:0] ATTACK_RST  = 16'd6554;
	localparam logic [15:0] DECAY_RST   = 16'd6554;
	localparam logic [15:0] SUSTAIN_RST = 16'd45875;
	localparam logic [15:0] RELEASE_RST = 16'd13107;
	localparam logic [15:0] PEAK_RST    = 16'd65535;

	// One quotient bit per divider stage
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned Q_DEPTH   = 4;

	// Envelope segment a sample falls into
	typedef enum logic [2:0] {
		SEG_ZERO,
		SEG_ATTACK,
		SEG_DECAY,
		SEG_SUSTAIN,
		SEG_RELEASE
	} seg_t;

	typedef struct packed {
		logic [15:0] attack_frac;
		logic [15:0] decay_frac;
		logic [15:0] sustain_frac;
		logic [15:0] release_frac;
		logic [15:0] peak_level;
	} cfg_t;

	// Work handed from the front end to the divider
	typedef struct packed {
		seg_t        seg;
		logic [31:0] base;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/core/adsr_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_sample_if
// Valid/ready channel carrying one sample index per beat.
// ----------------------------------------------------------------------------
interface adsr_sample_if;
	logic       valid;
	logic       ready;
	logic [9:0] sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink (input valid, input sample_index, output ready);
endinterface

// ===== rtl/core/adsr_level_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_level_if
// Valid/ready channel carrying one envelope level per beat.
// ----------------------------------------------------------------------------
interface adsr_level_if;
	logic        valid;
	logic        ready;
	logic [15:0] envelope_level;

	modport source (output valid, output envelope_level, input ready);
	modport sink (input valid, input envelope_level, output ready);
endinterface

// ===== rtl/core/adsr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_front
// Classifies each index into its segment and builds the division operands
// over three stages: bounds compare, level multiply, numerator multiply.
// ----------------------------------------------------------------------------
module adsr_front import adsr_pkg::*; #(
	parameter int unsigned TABLE_LENGTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	adsr_sample_if.sink         sample_ch,
	input  q_stat_t             q_stat,
	output logic                push,
	output q_entry_t            push_entry
);

	localparam logic [32:0] NLEN = 33'(TABLE_LENGTH);
	localparam logic [32:0] SPAN = NLEN << 16;

	logic        v_s1, v_s2, v_s3;
	logic        ld_s1, ld_s2, ld_s3;
	seg_t        seg_s1, seg_s2;
	logic [31:0] off_s1, off_s2;
	logic [31:0] dvs_s1, dvs_s2;
	logic [31:0] lvl_s2, base_s2;
	q_entry_t    entry_s3;

	logic [32:0] x_w, a_w, d_w, r_w, ad_w, rs_w;
	seg_t        seg_w;
	logic [31:0] off_w, dvs_w;
	logic [16:0] fac_w;
	logic [32:0] lvl_w;
	logic [31:0] base_w;

	// Stage flow: each stage loads when empty or when it drains forward
	assign push      = v_s3 && !q_stat.full;
	assign ld_s3     = !v_s3 || push;
	assign ld_s2     = !v_s2 || ld_s3;
	assign ld_s1     = !v_s1 || ld_s2;
	assign sample_ch.ready = ld_s1;
	assign push_entry = entry_s3;

	// Segment bounds and offset into the segment
	always_comb begin
		x_w   = {7'b0, sample_ch.sample_index, 16'b0};
		a_w   = {17'b0, cfg.attack_frac} * NLEN;
		d_w   = {17'b0, cfg.decay_frac} * NLEN;
		r_w   = {17'b0, cfg.release_frac} * NLEN;
		ad_w  = a_w + d_w;
		rs_w  = SPAN - r_w;
		seg_w = SEG_ZERO;
		off_w = '0;
		dvs_w = '0;
		if ({23'b0, sample_ch.sample_index} >= NLEN) begin
			seg_w = SEG_ZERO;
		end else if (x_w < a_w) begin
			seg_w = SEG_ATTACK;
			off_w = x_w[31:0];
			dvs_w = a_w[31:0];
		end else if (x_w < ad_w) begin
			seg_w = SEG_DECAY;
			off_w = 32'(x_w - a_w);
			dvs_w = d_w[31:0];
		end else if (x_w < rs_w) begin
			seg_w = SEG_SUSTAIN;
		end else if (r_w == '0) begin
			seg_w = SEG_ZERO;
		end else begin
			seg_w = SEG_RELEASE;
			off_w = 32'(x_w - rs_w);
			dvs_w = r_w[31:0];
		end
	end

	// Level scale: peak, peak minus sustain, or sustain (Q16.16)
	always_comb begin
		case (seg_s1)
			SEG_ATTACK: fac_w = 17'h10000;
			SEG_DECAY:  fac_w = 17'h10000 - {1'b0, cfg.sustain_frac};
			default:    fac_w = {1'b0, cfg.sustain_frac};
		endcase
		lvl_w  = {17'b0, cfg.peak_level} * {16'b0, fac_w};
		base_w = (seg_s1 == SEG_DECAY) ? {cfg.peak_level, 16'b0} : lvl_w[31:0];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= sample_ch.valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			seg_s1 <= seg_w;
			off_s1 <= off_w;
			dvs_s1 <= dvs_w;
		end
		if (ld_s2) begin
			seg_s2  <= seg_s1;
			off_s2  <= off_s1;
			dvs_s2  <= dvs_s1;
			lvl_s2  <= lvl_w[31:0];
			base_s2 <= base_w;
		end
		if (ld_s3) begin
			entry_s3.seg      <= seg_s2;
			entry_s3.base     <= base_s2;
			entry_s3.dividend <= {32'b0, lvl_s2} * {32'b0, off_s2};
			entry_s3.divisor  <= dvs_s2;
		end
	end

endmodule

// ===== rtl/core/adsr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_queue
// Small FIFO decoupling the front end from the divider pipeline.
// ----------------------------------------------------------------------------
module adsr_queue import adsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wdata,
	input  logic     pop,
	output q_entry_t rdata,
	output q_stat_t  stat
);

	localparam int unsigned PW = $clog2(Q_DEPTH);

	q_entry_t        mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign stat.full  = (cnt_q == (PW+1)'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

// ===== rtl/core/adsr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_back
// Pipelined restoring divider, one quotient bit per stage, followed by the
// level assembly and the output register.
// ----------------------------------------------------------------------------
module adsr_back import adsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_stat_t     q_stat,
	input  q_entry_t    head,
	output logic        pop,
	adsr_level_if.source level_ch
);

	logic        v_q    [DIV_STEPS+1];
	logic [31:0] rem_q  [DIV_STEPS+1];
	logic [31:0] lo_q   [DIV_STEPS+1];
	logic [31:0] dvs_q  [DIV_STEPS+1];
	seg_t        seg_q  [DIV_STEPS+1];
	logic [31:0] base_q [DIV_STEPS+1];

	logic [32:0] trial_w [DIV_STEPS];
	logic        ge_w    [DIV_STEPS];
	logic [31:0] nrem_w  [DIV_STEPS];

	logic        out_v_q;
	logic [15:0] level_q;
	logic        adv;
	logic [31:0] quo_w, diff_w;
	logic [15:0] level_w;

	// Whole pipeline moves when the output slot is free or being taken
	assign adv   = !out_v_q || level_ch.ready;
	assign pop   = adv && !q_stat.empty;
	assign level_ch.valid          = out_v_q;
	assign level_ch.envelope_level = level_q;

	// One compare-subtract per stage
	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial_w[k] = {rem_q[k], lo_q[k][31]};
			ge_w[k]    = trial_w[k] >= {1'b0, dvs_q[k]};
			nrem_w[k]  = ge_w[k] ? 32'(trial_w[k] - {1'b0, dvs_q[k]}) : trial_w[k][31:0];
		end
	end

	// Level from quotient and segment
	always_comb begin
		quo_w  = lo_q[DIV_STEPS];
		diff_w = base_q[DIV_STEPS] - quo_w;
		case (seg_q[DIV_STEPS])
			SEG_ATTACK:  level_w = quo_w[31:16];
			SEG_DECAY:   level_w = diff_w[31:16];
			SEG_SUSTAIN: level_w = base_q[DIV_STEPS][31:16];
			SEG_RELEASE: level_w = (quo_w >= base_q[DIV_STEPS]) ? 16'd0 : diff_w[31:16];
			default:     level_w = 16'd0;
		endcase
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) v_q[k] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_q[0] <= !q_stat.empty;
			for (int k = 1; k <= DIV_STEPS; k++) v_q[k] <= v_q[k-1];
			out_v_q <= v_q[DIV_STEPS];
		end
	end

	// Divider payload
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0]  <= head.dividend[63:32];
			lo_q[0]   <= head.dividend[31:0];
			dvs_q[0]  <= head.divisor;
			seg_q[0]  <= head.seg;
			base_q[0] <= head.base;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				rem_q[k]  <= nrem_w[k-1];
				lo_q[k]   <= {lo_q[k-1][30:0], ge_w[k-1]};
				dvs_q[k]  <= dvs_q[k-1];
				seg_q[k]  <= seg_q[k-1];
				base_q[k] <= base_q[k-1];
			end
			level_q <= level_w;
		end
	end

endmodule

// ===== rtl/core/adsr_envelope_sample.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_sample
// ADSR envelope level at a given sample index, with APB register access.
//
//   channel    dir  beat payload
//   sample_ch  in   sample_index[9:0]
//   level_ch   out  envelope_level[15:0]
//   apb        in   attack/decay/sustain/release fractions, peak level
//
// One index accepted per cycle when nothing stalls; each index passes through
// the 3-stage front end, the queue and the 32-stage divider pipeline.
// arst_n clears all valid bits and loads the register defaults.
// A stall on level_ch freezes the divider; the front end and its 4-entry
// queue keep taking indexes until the queue and the front stages fill.
// ----------------------------------------------------------------------------
module adsr_envelope_sample import adsr_pkg::*; #(
	parameter int unsigned TABLE_LENGTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	adsr_sample_if.sink  sample_ch,
	adsr_level_if.source level_ch
);

	localparam int unsigned MAX_FLIGHT = 3 + Q_DEPTH + DIV_STEPS + 2;

	cfg_t     cfg_q;
	logic     wr_en;
	logic     push, pop;
	q_entry_t push_entry, head;
	q_stat_t  q_stat;
	logic [6:0] flight_q;

	// Register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_frac  <= ATTACK_RST;
			cfg_q.decay_frac   <= DECAY_RST;
			cfg_q.sustain_frac <= SUSTAIN_RST;
			cfg_q.release_frac <= RELEASE_RST;
			cfg_q.peak_level   <= PEAK_RST;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_ATTACK:  cfg_q.attack_frac  <= pwdata[15:0];
				REG_DECAY:   cfg_q.decay_frac   <= pwdata[15:0];
				REG_SUSTAIN: cfg_q.sustain_frac <= pwdata[15:0];
				REG_RELEASE: cfg_q.release_frac <= pwdata[15:0];
				REG_PEAK:    cfg_q.peak_level   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_ATTACK:  prdata = {16'b0, cfg_q.attack_frac};
			REG_DECAY:   prdata = {16'b0, cfg_q.decay_frac};
			REG_SUSTAIN: prdata = {16'b0, cfg_q.sustain_frac};
			REG_RELEASE: prdata = {16'b0, cfg_q.release_frac};
			REG_PEAK:    prdata = {16'b0, cfg_q.peak_level};
			default:     prdata = '0;
		endcase
	end

	adsr_front #(.TABLE_LENGTH(TABLE_LENGTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.sample_ch  (sample_ch),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	adsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.rdata  (head),
		.stat   (q_stat)
	);

	adsr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.level_ch (level_ch)
	);

	// Items in flight, for checking only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else begin
			flight_q <= flight_q + 7'(sample_ch.valid && sample_ch.ready)
				- 7'(level_ch.valid && level_ch.ready);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("queue written while full");

	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q <= 7'(MAX_FLIGHT)) else $error("more items in flight than stages");

	a_out_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		level_ch.valid |-> flight_q != '0) else $error("result with no item in flight");

	a_under_peak: assert property (@(posedge clk) disable iff (!arst_n)
		level_ch.valid |-> level_ch.envelope_level <= cfg_q.peak_level)
		else $error("level above peak");

endmodule
